>>> design/msc_pkg.sv
// Shared types and constants for the marching-squares contour tracer.
package msc_pkg;
    localparam int MAX_ROW_LENGTH_DEF = 1024;
    localparam int FRACTION_BITS_DEF = 12;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_WIDTH = 11;
    localparam int POINT_WIDTH = 22;

    typedef struct packed {
        logic [31:0] sample_value;
        logic        sample_undefined;
        logic        frame_start;
    } t_in_item;

    typedef struct packed {
        logic [POINT_WIDTH-1:0] point_x;
        logic [POINT_WIDTH-1:0] point_y;
        logic                   last_of_run;
    } t_out_item;

    // Edge list entry: corner p and corner q (0 TL, 1 TR, 2 BL, 3 BR).
    typedef struct packed {
        logic [1:0] p;
        logic [1:0] q;
    } t_edge;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       load;      // take input item, read store
        logic       advance;   // latch corners and advance counters
        logic       div_start; // start one edge interpolation
        logic [1:0] edge_k;    // edge index within the cell
        logic       emit;      // load output register
        logic       last;      // last point of this sample
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic       div_done;
        logic [2:0] edge_n; // number of edges for the completed cell
    } t_stat;

    function automatic logic [2:0] edge_count(input logic [3:0] code);
        unique case (code)
            4'd0, 4'd15: edge_count = 3'd0;
            4'd5, 4'd10: edge_count = 3'd4;
            default:     edge_count = 3'd2;
        endcase
    endfunction

    function automatic t_edge edge_at(input logic [3:0] code, input logic [1:0] k);
        t_edge e;
        e = '{p: 2'd0, q: 2'd0};
        unique case (code)
            4'd1, 4'd14: e = (k == 2'd0) ? t_edge'{2'd0, 2'd2} : t_edge'{2'd2, 2'd3};
            4'd2, 4'd13: e = (k == 2'd0) ? t_edge'{2'd1, 2'd3} : t_edge'{2'd2, 2'd3};
            4'd3, 4'd12: e = (k == 2'd0) ? t_edge'{2'd0, 2'd2} : t_edge'{2'd1, 2'd3};
            4'd4, 4'd11: e = (k == 2'd0) ? t_edge'{2'd1, 2'd0} : t_edge'{2'd1, 2'd3};
            4'd6, 4'd9:  e = (k == 2'd0) ? t_edge'{2'd0, 2'd1} : t_edge'{2'd2, 2'd3};
            4'd7, 4'd8:  e = (k == 2'd0) ? t_edge'{2'd0, 2'd1} : t_edge'{2'd0, 2'd2};
            4'd5: begin
                unique case (k)
                    2'd0: e = '{2'd0, 2'd1};
                    2'd1: e = '{2'd0, 2'd2};
                    2'd2: e = '{2'd1, 2'd3};
                    default: e = '{2'd2, 2'd3};
                endcase
            end
            4'd10: begin
                unique case (k)
                    2'd0: e = '{2'd0, 2'd1};
                    2'd1: e = '{2'd1, 2'd3};
                    2'd2: e = '{2'd0, 2'd2};
                    default: e = '{2'd2, 2'd3};
                endcase
            end
            default: e = '{2'd0, 2'd0};
        endcase
        return e;
    endfunction
endpackage

>>> design/marching_squares_contour_top.sv
// Marching-squares zero-contour tracer; each crossing point is interpolated with FRACTION_BITS+1
// division steps, and a sample with no crossings produces no point.
// The next sample is taken once the last point of the current one is in the output register,
// or once the current one is found to have no crossings.
// Synchronous active-low reset clears counters, the left and upper-left sample registers and
// control; the line buffer is not cleared and the row length returns to 1024.
module marching_squares_contour_top #(
    parameter int MAX_ROW_LENGTH = msc_pkg::MAX_ROW_LENGTH_DEF,
    parameter int FRACTION_BITS = msc_pkg::FRACTION_BITS_DEF,
    parameter int SAMPLE_WIDTH = msc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  msc_pkg::t_in_item             i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output msc_pkg::t_out_item            o_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [msc_pkg::CFG_WIDTH-1:0] i_cfg_data
);
    import msc_pkg::*;

    logic [CFG_WIDTH-1:0] r_row_length;
    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= CFG_WIDTH'(1024);
        end else if (i_cfg_valid) begin
            r_row_length <= i_cfg_data;
        end
    end

    msc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .i_stat (w_stat),
        .o_cmd  (w_cmd)
    );

    msc_datapath #(
        .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
        .FRACTION_BITS (FRACTION_BITS),
        .SAMPLE_WIDTH  (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_item      (i_data),
        .i_row_length(r_row_length),
        .o_item      (o_data)
    );

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output changed while stalled");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_cmd.load, w_cmd.advance, w_cmd.div_start, w_cmd.emit}) <= 1)
        else $error("overlapping datapath commands");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> !o_ready)
        else $error("input taken during interpolation");
`endif
endmodule

>>> design/msc_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module msc_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/msc_divider.sv
// Restoring divider: rounded quotient num*2^F/den, clamped to 2^F, one bit a cycle.
module msc_divider #(
    parameter int NUM_WIDTH = 33,
    parameter int FRAC_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_WIDTH-1:0] i_num,
    input  logic [NUM_WIDTH-1:0] i_den,
    output logic                 o_done,
    output logic [FRAC_BITS:0]   o_t
);
    // Quotient bits: F fraction bits plus one round bit.
    localparam int QB = FRAC_BITS + 1;
    localparam int CW = $clog2(QB + 1);
    localparam int RW = NUM_WIDTH + 1;

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] r_rem, n_rem;
    logic [NUM_WIDTH-1:0] r_den;
    logic [NUM_WIDTH-1:0] r_num;
    logic [QB-1:0] r_q;
    logic          r_big;
    logic          r_done;
    logic [RW-1:0] w_trial;
    logic          w_ge;

    // num >= den means t >= 1, clamp; otherwise num < den and long division on fractions.
    assign w_trial = {r_rem[RW-2:0], 1'b0};
    assign w_ge = w_trial >= {1'b0, r_den};
    assign n_rem = w_ge ? (w_trial - {1'b0, r_den}) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(QB - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= {1'b0, i_num};
            r_big <= (i_den == '0) ? 1'b0 : (i_num >= i_den);
            r_cnt <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            r_rem <= n_rem;
            r_q   <= {r_q[QB-2:0], w_ge};
        end
    end

    logic [QB:0]        w_qr;
    logic [FRAC_BITS:0] w_t;
    // r_q holds floor(num*2^(F+1)/den); rounding adds one then halves.
    always_comb begin
        w_qr = {1'b0, r_q} + (QB+1)'(1);
        w_t  = w_qr[QB:1];
        if (r_den == '0 || r_num == '0) begin
            w_t = '0;
        end else if (r_big || w_qr[QB:1] > QB'(1 << FRAC_BITS)) begin
            w_t = (FRAC_BITS+1)'(1 << FRAC_BITS);
        end
    end

    assign o_done = r_done;
    assign o_t    = w_t;
endmodule

>>> design/msc_datapath.sv
// Datapath: line buffer, corner registers, counters, edge select and point build.
module msc_datapath #(
    parameter int MAX_ROW_LENGTH = 1024,
    parameter int FRACTION_BITS = 12,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  msc_pkg::t_cmd                    i_cmd,
    output msc_pkg::t_stat                   o_stat,
    input  msc_pkg::t_in_item                i_item,
    input  logic [msc_pkg::CFG_WIDTH-1:0]    i_row_length,
    output msc_pkg::t_out_item               o_item
);
    import msc_pkg::*;

    localparam int AW = $clog2(MAX_ROW_LENGTH);
    localparam int CW = $clog2(MAX_ROW_LENGTH + 1);
    localparam int SW = SAMPLE_WIDTH + 1;
    localparam int DW = SAMPLE_WIDTH + 1;

    logic [SW-1:0] r_left, r_ul;
    logic [SW-1:0] r_c [4];
    logic [CW-1:0] r_col, r_row, r_cx, r_cy;
    logic [3:0]    w_code;
    logic          r_valid_cell;
    logic [SW-1:0] w_above;
    logic [CW-1:0] w_len, n_col, n_row;
    logic [CW-1:0] w_max;
    logic [31:0]   w_len_full;

    assign w_max = CW'(MAX_ROW_LENGTH);
    assign w_len_full = 32'(i_row_length);
    always_comb begin
        w_len = w_len_full[CW-1:0];
        if (w_len_full < 32'd2) w_len = CW'(2);
        else if (w_len_full > 32'(MAX_ROW_LENGTH)) w_len = w_max;
    end

    // r_smp: {undef, value} ; frame_start held separately in r_fs.
    logic [SW-1:0] r_smp;
    logic          r_fs;
    logic [AW-1:0] w_idx2;
    logic [CW-1:0] w_col2, w_row2;

    // Column and row as seen by the held sample (frame_start clears them).
    assign w_col2 = r_fs ? '0 : r_col;
    assign w_row2 = r_fs ? '0 : r_row;
    assign w_idx2 = (w_col2 < w_max) ? w_col2[AW-1:0] : AW'(MAX_ROW_LENGTH - 1);

    msc_ram #(.WIDTH(SW), .DEPTH(MAX_ROW_LENGTH)) u_line (
        .i_clk  (i_clk),
        .i_we   (i_cmd.advance),
        .i_waddr(w_idx2),
        .i_wdata(r_smp),
        .i_raddr(w_idx2),
        .o_rdata(w_above)
    );

    always_comb begin
        n_col = w_col2 + CW'(1);
        n_row = w_row2;
        if (n_col >= w_len) begin
            n_col = '0;
            n_row = w_row2 + CW'(1);
            if (n_row >= w_len) n_row = '0;
        end
    end

    logic w_neg [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_neg[i] = r_c[i][SAMPLE_WIDTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
            r_ul   <= '0;
            r_valid_cell <= 1'b0;
        end else if (i_cmd.advance) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_left <= r_smp;
            r_ul   <= w_above;
            r_valid_cell <= (w_col2 != '0) && (w_row2 != '0) &&
                            !(r_ul[SW-1] | w_above[SW-1] | r_left[SW-1] | r_smp[SW-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_smp <= {i_item.sample_undefined, i_item.sample_value[SAMPLE_WIDTH-1:0]};
            r_fs  <= i_item.frame_start;
        end
        if (i_cmd.advance) begin
            r_c[0] <= r_ul;
            r_c[1] <= w_above;
            r_c[2] <= r_left;
            r_c[3] <= r_smp;
            r_cx   <= w_col2 - CW'(1);
            r_cy   <= w_row2 - CW'(1);
        end
    end

    assign w_code = {w_neg[0], w_neg[1], w_neg[3], w_neg[2]};

    // Edge operands for the interpolation.
    t_edge w_e;
    logic signed [SAMPLE_WIDTH:0] w_f1, w_f2, w_d;
    logic [DW-1:0] w_num, w_den;
    assign w_e  = edge_at(w_code, i_cmd.edge_k);
    assign w_f1 = {r_c[w_e.p][SAMPLE_WIDTH-1], r_c[w_e.p][SAMPLE_WIDTH-1:0]};
    assign w_f2 = {r_c[w_e.q][SAMPLE_WIDTH-1], r_c[w_e.q][SAMPLE_WIDTH-1:0]};
    assign w_d  = w_f2 - w_f1;
    assign w_num = w_f1[SAMPLE_WIDTH] ? DW'(-w_f1) : DW'(w_f1);
    assign w_den = w_d[SAMPLE_WIDTH] ? DW'(-w_d) : DW'(w_d);

    logic r_dir_x, r_dir_y, r_neg_x, r_neg_y;
    logic [CW:0] r_bx, r_by;
    logic [FRACTION_BITS:0] w_t;
    logic w_done;

    msc_divider #(.NUM_WIDTH(DW), .FRAC_BITS(FRACTION_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_done),
        .o_t    (w_t)
    );

    // Corner coordinates: bit0 = dx, bit1 = dy.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_bx    <= {1'b0, r_cx} + (CW+1)'(w_e.p[0]);
            r_by    <= {1'b0, r_cy} + (CW+1)'(w_e.p[1]);
            r_dir_x <= w_e.p[0] != w_e.q[0];
            r_neg_x <= w_e.p[0] & ~w_e.q[0];
            r_dir_y <= w_e.p[1] != w_e.q[1];
            r_neg_y <= w_e.p[1] & ~w_e.q[1];
        end
    end

    localparam int PW = CW + 1 + FRACTION_BITS;
    logic [PW-1:0] w_px, w_py, w_tx;
    always_comb begin
        w_tx = PW'(w_t);
        w_px = {r_bx, {FRACTION_BITS{1'b0}}};
        w_py = {r_by, {FRACTION_BITS{1'b0}}};
        if (r_dir_x) w_px = r_neg_x ? (w_px - w_tx) : (w_px + w_tx);
        if (r_dir_y) w_py = r_neg_y ? (w_py - w_tx) : (w_py + w_tx);
    end

    logic [POINT_WIDTH-1:0] r_ox, r_oy;
    logic r_ol;
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ox <= POINT_WIDTH'(w_px);
            r_oy <= POINT_WIDTH'(w_py);
            r_ol <= i_cmd.last;
        end
    end

    assign o_item = '{point_x: r_ox, point_y: r_oy, last_of_run: r_ol};
    assign o_stat = '{div_done: w_done,
                      edge_n: r_valid_cell ? edge_count(w_code) : 3'd0};
endmodule

>>> design/msc_ctrl.sv
// Controller: sequences load, store read, cell update and edge interpolations.
module msc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  msc_pkg::t_stat i_stat,
    output msc_pkg::t_cmd  o_cmd
);
    import msc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CELL = 3'd2;
    localparam logic [2:0] S_EDGE = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       r_ov, n_ov;
    logic       w_last;

    assign w_last = ({1'b0, r_k} + 3'd1) == i_stat.edge_n;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_ov    = r_ov;
        o_cmd   = '{load: 1'b0, advance: 1'b0, div_start: 1'b0, edge_k: r_k,
                    emit: 1'b0, last: w_last};
        o_ready = 1'b0;
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_CELL; // store read data lands
            S_CELL: begin
                o_cmd.advance = 1'b1;
                n_k = 2'd0;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                if (i_stat.edge_n == 3'd0) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: if (i_stat.div_done) n_state = S_OUT;
            S_OUT: begin
                // hold until the output register is free
                if (!r_ov || i_ready) begin
                    o_cmd.emit = 1'b1;
                    n_ov = 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 2'd1;
                        n_state = S_EDGE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_ov    <= n_ov;
        end
    end

    assign o_valid = r_ov;
endmodule
